[sv/upce_pkg.sv]
package upce_pkg;

	localparam int unsigned NIB_W   = 4;
	localparam int unsigned UPCA_N  = 12;
	localparam int unsigned UPCE_N  = 8;
	localparam int unsigned WORD_W  = UPCA_N * NIB_W;
	localparam int unsigned UPCE_W  = UPCE_N * NIB_W;
	localparam int unsigned SUM_W   = 8;

	localparam logic [NIB_W-1:0] DIG_NINE  = 4'd9;
	localparam logic [NIB_W-1:0] DIG_THREE = 4'd3;
	localparam logic [NIB_W-1:0] DIG_FOUR  = 4'd4;
	localparam logic [NIB_W-1:0] DIG_ZERO  = 4'd0;

	localparam logic OP_EXPAND   = 1'b0;
	localparam logic OP_COMPRESS = 1'b1;

	typedef logic [NIB_W-1:0]  digit_t;
	typedef logic [WORD_W-1:0] upca_t;
	typedef logic [UPCE_W-1:0] upce_t;
	typedef logic [SUM_W-1:0]  csum_t;

	// Digit i of a 12-digit word, first digit in the top nibble.
	function automatic digit_t a_dig(upca_t w, int unsigned i);
		return w[WORD_W-1-NIB_W*i -: NIB_W];
	endfunction

	function automatic digit_t e_dig(upce_t w, int unsigned i);
		return w[UPCE_W-1-NIB_W*i -: NIB_W];
	endfunction

	// Per nibble: 1 where the nibble holds a decimal digit.
	function automatic logic [UPCA_N-1:0] dec_flags(upca_t w);
		logic [UPCA_N-1:0] f;
		for (int i = 0; i < UPCA_N; i++)
			f[i] = (w[NIB_W*i +: NIB_W] <= DIG_NINE);
		return f;
	endfunction

	// Zero-insertion pattern picked by the sixth body digit.
	function automatic upca_t expand(upce_t e);
		digit_t ns, b1, b2, b3, b4, b5, b6, ck;
		upca_t  a;
		ns = e_dig(e, 0);
		b1 = e_dig(e, 1);
		b2 = e_dig(e, 2);
		b3 = e_dig(e, 3);
		b4 = e_dig(e, 4);
		b5 = e_dig(e, 5);
		b6 = e_dig(e, 6);
		ck = e_dig(e, 7);
		case (b6)
			4'd0, 4'd1, 4'd2: a = {ns, b1, b2, b6, DIG_ZERO, DIG_ZERO, DIG_ZERO, DIG_ZERO,
				b3, b4, b5, ck};
			DIG_THREE: a = {ns, b1, b2, b3, DIG_ZERO, DIG_ZERO, DIG_ZERO, DIG_ZERO,
				DIG_ZERO, b4, b5, ck};
			DIG_FOUR: a = {ns, b1, b2, b3, b4, DIG_ZERO, DIG_ZERO, DIG_ZERO,
				DIG_ZERO, DIG_ZERO, b5, ck};
			default: a = {ns, b1, b2, b3, b4, b5, DIG_ZERO, DIG_ZERO,
				DIG_ZERO, DIG_ZERO, b6, ck};
		endcase
		return a;
	endfunction

endpackage

[sv/upce_in_if.sv]
interface upce_in_if;
	import upce_pkg::*;

	logic  valid;
	logic  ready;
	logic  operation;
	upca_t digits;

	modport source (output valid, output operation, output digits, input ready);
	modport sink (input valid, input operation, input digits, output ready);
endinterface

[sv/upce_out_if.sv]
interface upce_out_if;
	import upce_pkg::*;

	logic  valid;
	logic  ready;
	logic  ok;
	upca_t result_digits;

	modport source (output valid, output ok, output result_digits, input ready);
	modport sink (input valid, input ok, input result_digits, output ready);
endinterface

[sv/upc_e_upc_a_convert.sv]
// channel  | direction | payload
// in_ch    | sink      | operation (1), digits (48)
// out_ch   | source    | ok (1), result_digits (48)
//
// Three register stages: operand decode and candidate match, weighted check
// sum, mod-10 check and result register. One code enters per cycle unless
// the output stalls. All stages advance together whenever the result register
// is empty or being taken, so a stall holds every stage in place.
// Reset clears the stage valid bits only.
module upc_e_upc_a_convert (
	input logic           clk,
	input logic           arst_n,
	upce_in_if.sink       in_ch,
	upce_out_if.source    out_ch
);
	import upce_pkg::*;

	logic adv;

	// stage 1 inputs
	upca_t             in_w;
	upca_t             exp_w;
	logic [UPCA_N-1:0] dec;
	upce_t             cand [4];
	logic [3:0]        hit;
	upce_t             pick;
	logic              pre;
	upca_t             chk_w;
	upca_t             res_w;

	logic  v_s1, pre_s1;
	upca_t chk_s1, res_s1;

	csum_t  sum;
	logic   v_s2, pre_s2;
	csum_t  sum_s2;
	digit_t ck_s2;
	upca_t  res_s2;

	logic [15:0]     q_prod;
	logic [4:0]      quo;
	csum_t           rem_w;
	logic [NIB_W:0]  tot;
	logic            chk;

	logic  v_s3, ok_s3;
	upca_t res_s3;

	assign adv         = !v_s3 || out_ch.ready;
	assign in_ch.ready = adv;

	assign in_w = in_ch.digits;
	assign dec  = dec_flags(in_w);
	assign exp_w = expand(in_w[UPCE_W-1:0]);

	always_comb begin
		cand[0] = {a_dig(in_w, 0), a_dig(in_w, 1), a_dig(in_w, 2), a_dig(in_w, 8),
			a_dig(in_w, 9), a_dig(in_w, 10), a_dig(in_w, 3), a_dig(in_w, 11)};
		cand[1] = {a_dig(in_w, 0), a_dig(in_w, 1), a_dig(in_w, 2), a_dig(in_w, 3),
			a_dig(in_w, 9), a_dig(in_w, 10), DIG_THREE, a_dig(in_w, 11)};
		cand[2] = {a_dig(in_w, 0), a_dig(in_w, 1), a_dig(in_w, 2), a_dig(in_w, 3),
			a_dig(in_w, 4), a_dig(in_w, 10), DIG_FOUR, a_dig(in_w, 11)};
		cand[3] = {a_dig(in_w, 0), a_dig(in_w, 1), a_dig(in_w, 2), a_dig(in_w, 3),
			a_dig(in_w, 4), a_dig(in_w, 5), a_dig(in_w, 10), a_dig(in_w, 11)};
		// candidates are decimal whenever the input is, so only the round trip counts
		for (int k = 0; k < 4; k++)
			hit[k] = (expand(cand[k]) == in_w);
		pick = cand[3];
		for (int k = 2; k >= 0; k--)
			if (hit[k])
				pick = cand[k];
	end

	always_comb begin
		if (in_ch.operation == OP_EXPAND) begin
			pre   = (&dec[UPCE_N-1:0]) && (e_dig(in_w[UPCE_W-1:0], 0) <= 4'd1);
			chk_w = exp_w;
			res_w = exp_w;
		end else begin
			pre   = (&dec) && (a_dig(in_w, 0) <= 4'd1) && (|hit);
			chk_w = in_w;
			res_w = {{(WORD_W-UPCE_W){1'b0}}, pick};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s1 <= pre;
			chk_s1 <= chk_w;
			res_s1 <= res_w;
		end
	end

	// weights 3,1,3,... from the digit next to the check digit leftwards
	always_comb begin
		sum = '0;
		for (int i = 0; i < UPCA_N - 1; i++)
			if ((i % 2) == 0)
				sum = sum + SUM_W'(a_dig(chk_s1, i)) * SUM_W'(3);
			else
				sum = sum + SUM_W'(a_dig(chk_s1, i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_s2 <= pre_s1;
			sum_s2 <= sum;
			ck_s2  <= a_dig(chk_s1, UPCA_N - 1);
			res_s2 <= res_s1;
		end
	end

	// sum / 10 by reciprocal, exact for every 8-bit sum
	assign q_prod = 16'(sum_s2) * 16'd205;
	assign quo    = q_prod[15:11];
	assign rem_w  = sum_s2 - ({3'b000, quo} << 3) - ({3'b000, quo} << 1);
	assign tot    = {1'b0, rem_w[NIB_W-1:0]} + {1'b0, ck_s2};
	assign chk    = (tot == 5'd0) || (tot == 5'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3  <= pre_s2 && chk;
			res_s3 <= (pre_s2 && chk) ? res_s2 : '0;
		end
	end

	assign out_ch.valid         = v_s3;
	assign out_ch.ok            = ok_s3;
	assign out_ch.result_digits = res_s3;

endmodule
